// ===== design/cfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

    localparam int FRAME_LEN = 6;
    localparam int FILL_W    = 3;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0] CLASS_RECORD   = 8'h02;
    localparam logic [7:0] CLASS_TRANSFER = 8'h14;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_RECORD_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_RECORD_STOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_TRANSFER_START = 3'd4;

    localparam logic [7:0] RST_HEADER_FIRST        = 8'd0;
    localparam logic [7:0] RST_HEADER_SECOND       = 8'd0;
    localparam logic [7:0] RST_CODE_RECORD_START   = 8'd1;
    localparam logic [7:0] RST_CODE_RECORD_STOP    = 8'd2;
    localparam logic [7:0] RST_CODE_TRANSFER_START = 8'd3;

    // frame events
    localparam logic [1:0] EVT_NONE    = 2'd0;
    localparam logic [1:0] EVT_FRAME   = 2'd1;
    localparam logic [1:0] EVT_SUM_ERR = 2'd2;

    // response codes
    localparam logic [3:0] RESP_NONE        = 4'd0;
    localparam logic [3:0] RESP_BUSY        = 4'd1;
    localparam logic [3:0] RESP_ALREADY     = 4'd2;
    localparam logic [3:0] RESP_STARTED     = 4'd3;
    localparam logic [3:0] RESP_STOPPED     = 4'd4;
    localparam logic [3:0] RESP_NOT_RECORD  = 4'd5;
    localparam logic [3:0] RESP_TX_OK       = 4'd6;
    localparam logic [3:0] RESP_TX_ERR      = 4'd7;
    localparam logic [3:0] RESP_BAD_CMD     = 4'd8;

    // record requests
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;

    // last command codes
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_REC_START = 3'd1;
    localparam logic [2:0] CMD_REC_STOP  = 3'd2;
    localparam logic [2:0] CMD_TRANSFER  = 3'd3;
    localparam logic [2:0] CMD_UNKNOWN   = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       transfer_busy;
        logic       recording_active;
        logic       transfer_start_ok;
    } item_t;

    typedef struct packed {
        logic [1:0]       frame_event;
        logic [3:0]       response_code;
        logic [1:0]       record_request;
        logic             start_transfer;
        logic [2:0]       last_command_out;
        logic [CNT_W-1:0] bytes_seen;
        logic [CNT_W-1:0] good_frames;
        logic [CNT_W-1:0] unknown_count;
        logic [CNT_W-1:0] sum_errors;
    } result_t;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] code_record_start;
        logic [7:0] code_record_stop;
        logic [7:0] code_transfer_start;
    } cfg_t;

endpackage

`default_nettype wire

// ===== design/cfp_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfp_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [cfp_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [7:0]                    wr_data,
    output cfp_pkg::cfg_t                      cfg
);

    cfp_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first        <= cfp_pkg::RST_HEADER_FIRST;
            cfg_reg.header_second       <= cfp_pkg::RST_HEADER_SECOND;
            cfg_reg.code_record_start   <= cfp_pkg::RST_CODE_RECORD_START;
            cfg_reg.code_record_stop    <= cfp_pkg::RST_CODE_RECORD_STOP;
            cfg_reg.code_transfer_start <= cfp_pkg::RST_CODE_TRANSFER_START;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                cfp_pkg::CFG_HEADER_FIRST:        cfg_reg.header_first        <= wr_data;
                cfp_pkg::CFG_HEADER_SECOND:       cfg_reg.header_second       <= wr_data;
                cfp_pkg::CFG_CODE_RECORD_START:   cfg_reg.code_record_start   <= wr_data;
                cfp_pkg::CFG_CODE_RECORD_STOP:    cfg_reg.code_record_stop    <= wr_data;
                cfp_pkg::CFG_CODE_TRANSFER_START: cfg_reg.code_transfer_start <= wr_data;
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/cfp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfp_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           proc,
    input  wire cfp_pkg::item_t item,
    input  wire cfp_pkg::cfg_t  cfg,
    output cfp_pkg::result_t    result
);

    localparam int LAST = cfp_pkg::FRAME_LEN - 1;

    logic [7:0]                   win_reg  [cfp_pkg::FRAME_LEN];
    logic [7:0]                   win_next [cfp_pkg::FRAME_LEN];
    logic [7:0]                   w        [cfp_pkg::FRAME_LEN];
    logic [cfp_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [2:0]                   last_cmd_reg, last_cmd_next;
    logic [cfp_pkg::CNT_W-1:0]    byte_cnt_reg, byte_cnt_next;
    logic [cfp_pkg::CNT_W-1:0]    valid_cnt_reg, valid_cnt_next;
    logic [cfp_pkg::CNT_W-1:0]    unknown_cnt_reg, unknown_cnt_next;
    logic [cfp_pkg::CNT_W-1:0]    sum_cnt_reg, sum_cnt_next;
    logic [7:0]                   sum;
    logic                         full, hdr_ok, sum_ok;
    logic [1:0]                   event_c, req_c;
    logic [3:0]                   resp_c;
    logic                         pulse_c;

    // window with the new byte placed at the fill position
    always_comb
    begin
        for (int i = 0; i < LAST; i++)
        begin
            w[i] = (fill_reg == cfp_pkg::FILL_W'(i)) ? item.rx_byte : win_reg[i];
        end
        w[LAST] = (fill_reg >= cfp_pkg::FILL_W'(LAST)) ? item.rx_byte : win_reg[LAST];
    end

    assign full   = (fill_reg >= cfp_pkg::FILL_W'(LAST));
    assign sum    = w[0] + w[1] + w[2] + w[3] + w[4];
    assign hdr_ok = (w[0] == cfg.header_first) && (w[1] == cfg.header_second);
    assign sum_ok = (sum == w[5]);

    always_comb
    begin
        event_c          = cfp_pkg::EVT_NONE;
        resp_c           = cfp_pkg::RESP_NONE;
        req_c            = cfp_pkg::REQ_NONE;
        pulse_c          = 1'b0;
        last_cmd_next    = last_cmd_reg;
        byte_cnt_next    = byte_cnt_reg + 1'b1;
        valid_cnt_next   = valid_cnt_reg;
        unknown_cnt_next = unknown_cnt_reg;
        sum_cnt_next     = sum_cnt_reg;
        fill_next        = fill_reg + 1'b1;
        win_next         = w;

        if (full)
        begin
            if (hdr_ok && sum_ok)
            begin
                event_c        = cfp_pkg::EVT_FRAME;
                valid_cnt_next = valid_cnt_reg + 1'b1;
                fill_next      = '0;
                // first match wins: start, stop, transfer
                if (w[2] == cfp_pkg::CLASS_RECORD && w[4] == cfg.code_record_start)
                begin
                    last_cmd_next = cfp_pkg::CMD_REC_START;
                    if (item.transfer_busy)
                    begin
                        resp_c = cfp_pkg::RESP_BUSY;
                    end
                    else if (item.recording_active)
                    begin
                        resp_c = cfp_pkg::RESP_ALREADY;
                    end
                    else
                    begin
                        req_c  = cfp_pkg::REQ_START;
                        resp_c = cfp_pkg::RESP_STARTED;
                    end
                end
                else if (w[2] == cfp_pkg::CLASS_RECORD && w[4] == cfg.code_record_stop)
                begin
                    last_cmd_next = cfp_pkg::CMD_REC_STOP;
                    if (item.recording_active)
                    begin
                        req_c  = cfp_pkg::REQ_STOP;
                        resp_c = cfp_pkg::RESP_STOPPED;
                    end
                    else
                    begin
                        resp_c = cfp_pkg::RESP_NOT_RECORD;
                    end
                end
                else if (w[2] == cfp_pkg::CLASS_TRANSFER && w[4] == cfg.code_transfer_start)
                begin
                    last_cmd_next = cfp_pkg::CMD_TRANSFER;
                    pulse_c       = 1'b1;
                    resp_c        = item.transfer_start_ok ? cfp_pkg::RESP_TX_OK
                                                           : cfp_pkg::RESP_TX_ERR;
                end
                else
                begin
                    last_cmd_next    = cfp_pkg::CMD_UNKNOWN;
                    unknown_cnt_next = unknown_cnt_reg + 1'b1;
                    resp_c           = cfp_pkg::RESP_BAD_CMD;
                end
            end
            else
            begin
                if (hdr_ok)
                begin
                    event_c      = cfp_pkg::EVT_SUM_ERR;
                    sum_cnt_next = sum_cnt_reg + 1'b1;
                end
                // drop the oldest byte to resync
                for (int i = 0; i < LAST; i++)
                begin
                    win_next[i] = w[i+1];
                end
                fill_next = cfp_pkg::FILL_W'(LAST);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            last_cmd_reg    <= cfp_pkg::CMD_NONE;
            byte_cnt_reg    <= '0;
            valid_cnt_reg   <= '0;
            unknown_cnt_reg <= '0;
            sum_cnt_reg     <= '0;
        end
        else if (proc)
        begin
            fill_reg        <= fill_next;
            last_cmd_reg    <= last_cmd_next;
            byte_cnt_reg    <= byte_cnt_next;
            valid_cnt_reg   <= valid_cnt_next;
            unknown_cnt_reg <= unknown_cnt_next;
            sum_cnt_reg     <= sum_cnt_next;
        end
    end

    // window bytes are payload, no reset
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            win_reg <= win_next;
        end
    end

    assign result.frame_event      = event_c;
    assign result.response_code    = resp_c;
    assign result.record_request   = req_c;
    assign result.start_transfer   = pulse_c;
    assign result.last_command_out = last_cmd_next;
    assign result.bytes_seen       = byte_cnt_next;
    assign result.good_frames      = valid_cnt_next;
    assign result.unknown_count    = unknown_cnt_next;
    assign result.sum_errors       = sum_cnt_next;

endmodule

`default_nettype wire

// ===== design/command_frame_parser.sv =====
// Path: an accepted item is held in the input register, its result in the result register.
// Throughput: 1 item per cycle unless out_stall holds the result register; the frame
// check and dispatch are combinational, between the input register and the result register.
// Reset: rst_n asynchronous, active low; clears counters, fill, last command
// and valid bits, loads config registers with their defaults. Window bytes are not reset.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_parser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire cfp_pkg::item_t                in_data,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output cfp_pkg::result_t                   out_data,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [cfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data
);

    logic              s1_valid_reg;
    cfp_pkg::item_t    s1_data_reg;
    logic              out_valid_reg;
    cfp_pkg::result_t  out_data_reg;
    logic              advance;
    cfp_pkg::cfg_t     cfg;
    cfp_pkg::result_t  result;

    assign cfg_ready = 1'b1;

    // result register free or draining this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;

    cfp_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    cfp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .proc   (s1_valid_reg && advance),
        .item   (s1_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_valid_reg && advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== design/cfp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfp_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire cfp_pkg::result_t out_data
);

    logic [cfp_pkg::CNT_W-1:0] prev_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_bytes_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            prev_bytes_reg <= out_data.bytes_seen;
        end
    end

    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("out_data changed while stalled");

    // every item counts exactly one byte, results in order
    a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.bytes_seen == prev_bytes_reg + 1'b1)
        else $error("bytes_seen not one past previous item");

    a_quiet_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_event != cfp_pkg::EVT_FRAME |->
            out_data.response_code == cfp_pkg::RESP_NONE &&
            out_data.record_request == cfp_pkg::REQ_NONE &&
            !out_data.start_transfer)
        else $error("response outputs set without an executed frame");

    a_pulse_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.start_transfer |->
            out_data.last_command_out == cfp_pkg::CMD_TRANSFER &&
            (out_data.response_code == cfp_pkg::RESP_TX_OK ||
             out_data.response_code == cfp_pkg::RESP_TX_ERR))
        else $error("start_transfer without transfer command");

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
